>>> rtl/core/lmss_pkg.sv
// lmss_pkg: shared types and constants for the led matrix scroll scanner
// holds the item and result word structs, register indexes and reset values
// no dependencies
package lmss_pkg;

	// item operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SCROLL_MODE      = 2'd0,
		CFG_DWELL_TICKS      = 2'd1,
		CFG_STATIC_FRAMES    = 2'd2,
		CFG_FRAMES_PER_SHIFT = 2'd3
	} cfg_reg_t;

	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic        SCROLL_MODE_RST      = 1'b1;
	localparam logic [15:0] DWELL_TICKS_RST      = 16'd2500;
	localparam logic [7:0]  STATIC_FRAMES_RST    = 8'd50;
	localparam logic [7:0]  FRAMES_PER_SHIFT_RST = 8'd15;

	localparam int ENABLE_W = 8;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic       is_last;
	} item_word_t;

	typedef struct packed {
		logic [ENABLE_W-1:0] column_enable_n;
		logic [7:0]          row_bits;
		logic                running;
		logic                done_res;
	} result_word_t;

endpackage

>>> rtl/core/lmss_store.sv
// lmss_store: message byte store with per-entry valid bits
// entries never written since reset read as zero; registered read with write forwarding
// no package dependencies
module lmss_store #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_byte
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_data_q;
	logic             rd_ok_q;
	logic             fwd;

	// same-edge write to the address being read
	assign fwd = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= fwd ? wr_data : mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= fwd || vld_q[rd_addr];
			end
		end
	end

	assign rd_byte = rd_ok_q ? rd_data_q : 8'd0;

endmodule

>>> rtl/core/led_matrix_scroll_scanner.sv
// led_matrix_scroll_scanner: top level of the column-multiplexed led matrix scanner
// depends on lmss_pkg and lmss_store
//
// Drives a MATRIX_SIZE-column led matrix one column at a time. Load words
// (operation = load) fill the message store, one column byte per word; the word
// with is_last set fixes the message length and starts a run. While running,
// each tick word counts toward dwell_ticks; when the dwell ends the scan moves
// to the next column, whose active-low enable is driven with the row bits of
// message byte (offset + column) mod length in scroll mode, or of byte
// column in static mode. Static mode shows the first bytes for static_frames
// refreshes; scroll mode holds each offset 0..length-2 for frames_per_shift
// refreshes. done_res pulses on the word that ends a run, and in scroll mode a
// message shorter than two bytes ends on its own last load word. Loads while a
// run is active are dropped, as are bytes past the store depth. Every word
// gives exactly one result word. A word is taken in every cycle in which the
// result register is empty or being drained, so the block runs at one word
// per clock; the result appears in the cycle after the word is taken, from the
// state registers and the store's registered read port. The store is cleared
// at reset through per-entry valid bits, so no clearing pass is needed and
// words are taken right after reset. Configuration writes are always ready
// and must only be issued while no word is in flight; a write during a run
// takes effect from the next word on, mode included.
module led_matrix_scroll_scanner #(
	parameter int MATRIX_SIZE   = 8,
	parameter int MESSAGE_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  lmss_pkg::item_word_t               item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output lmss_pkg::result_word_t             result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  lmss_pkg::cfg_reg_t                 cfg_index,
	input  logic [lmss_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import lmss_pkg::*;

	localparam int CW = $clog2(MATRIX_SIZE);
	localparam int AW = $clog2(MESSAGE_DEPTH);
	localparam int LW = $clog2(MESSAGE_DEPTH + 1);

	// configuration registers
	logic        scroll_mode_q;
	logic [15:0] dwell_ticks_q;
	logic [7:0]  static_frames_q;
	logic [7:0]  frames_per_shift_q;

	// scan state
	logic [LW-1:0] wp_q, wp_d;
	logic [LW-1:0] len_q, len_d;
	logic [CW-1:0] col_q, col_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [15:0]   dwell_q, dwell_d;
	logic [7:0]    frame_q, frame_d;
	logic [LW-1:0] offset_q, offset_d;
	logic          run_q, run_d;
	logic          done_q, done_d;
	// (offset + column) mod length, kept up in both modes so a mode change lands right
	logic [AW-1:0] sidx_q, sidx_d;

	// result register control
	logic          res_valid_q;
	logic          item_fire;

	// store access
	logic          wr_en;
	logic [7:0]    rd_byte;

	// intermediate values
	logic [LW-1:0] wp_inc;
	logic [16:0]   dwell_sum;
	logic [8:0]    frame_sum;
	logic [7:0]    frame_limit;
	logic [LW-1:0] offset_inc;
	logic [LW-1:0] sidx_ext;
	logic [CW-1:0] col_nxt;
	logic [AW-1:0] stat_idx;
	logic [ENABLE_W-1:0] col_en_n;

	// a word is held back only while the result register is full and stalled
	assign item_stall   = res_valid_q && result_stall;
	assign item_fire    = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign cfg_ready    = 1'b1;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_mode_q      <= SCROLL_MODE_RST;
			dwell_ticks_q      <= DWELL_TICKS_RST;
			static_frames_q    <= STATIC_FRAMES_RST;
			frames_per_shift_q <= FRAMES_PER_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCROLL_MODE: begin
					scroll_mode_q <= cfg_data[0];
				end
				CFG_DWELL_TICKS: begin
					dwell_ticks_q <= cfg_data[15:0];
				end
				CFG_STATIC_FRAMES: begin
					static_frames_q <= cfg_data[7:0];
				end
				CFG_FRAMES_PER_SHIFT: begin
					frames_per_shift_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// next scan state for the word being taken
	always_comb begin
		wp_d        = wp_q;
		len_d       = len_q;
		col_d       = col_q;
		idx_d       = idx_q;
		dwell_d     = dwell_q;
		frame_d     = frame_q;
		offset_d    = offset_q;
		run_d       = run_q;
		sidx_d      = sidx_q;
		done_d      = 1'b0;
		wr_en       = 1'b0;
		wp_inc      = wp_q;
		dwell_sum   = {1'b0, dwell_q} + 17'd1;
		frame_sum   = {1'b0, frame_q} + 9'd1;
		frame_limit = scroll_mode_q ? frames_per_shift_q : static_frames_q;
		offset_inc  = offset_q + LW'(1);
		sidx_ext    = LW'(sidx_q) + LW'(1);
		col_nxt     = col_q + CW'(1);
		// static mode shows byte column, wrapped at the store depth
		stat_idx    = (int'(col_nxt) >= MESSAGE_DEPTH) ?
			AW'(int'(col_nxt) - MESSAGE_DEPTH) : AW'(col_nxt);

		if (item_fire) begin
			if (item.operation == OP_LOAD) begin
				if (!run_q) begin
					// store is full once the write pointer reaches the depth
					if (wp_q < LW'(MESSAGE_DEPTH)) begin
						wr_en  = 1'b1;
						wp_inc = wp_q + LW'(1);
					end
					wp_d = wp_inc;
					if (item.is_last) begin
						len_d    = wp_inc;
						wp_d     = '0;
						col_d    = '0;
						idx_d    = '0;
						sidx_d   = '0;
						dwell_d  = '0;
						frame_d  = '0;
						offset_d = '0;
						if (scroll_mode_q && (wp_inc < LW'(2))) begin
							done_d = 1'b1;
						end else begin
							run_d = 1'b1;
						end
					end
				end
			end else if (run_q) begin
				if (dwell_sum >= {1'b0, dwell_ticks_q}) begin
					// dwell over: step to the next column
					dwell_d = '0;
					if (col_q != CW'(MATRIX_SIZE - 1)) begin
						col_d  = col_nxt;
						sidx_d = (sidx_ext == len_q) ? '0 : sidx_ext[AW-1:0];
						if (scroll_mode_q && (len_q != '0)) begin
							idx_d = sidx_d;
						end else begin
							idx_d = stat_idx;
						end
					end else begin
						// frame complete
						col_d  = '0;
						sidx_d = offset_q[AW-1:0];
						idx_d  = scroll_mode_q ? offset_q[AW-1:0] : '0;
						if (frame_sum >= {1'b0, frame_limit}) begin
							frame_d = '0;
							if (!scroll_mode_q) begin
								run_d = 1'b0;
							end else if ((offset_inc + LW'(1)) >= len_q) begin
								run_d = 1'b0;
							end else begin
								offset_d = offset_inc;
								sidx_d   = offset_inc[AW-1:0];
								idx_d    = offset_inc[AW-1:0];
							end
						end else begin
							frame_d = frame_sum[7:0];
						end
					end
					if (!run_d) begin
						done_d   = 1'b1;
						col_d    = '0;
						offset_d = '0;
						idx_d    = '0;
						sidx_d   = '0;
					end
				end else begin
					dwell_d = dwell_sum[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			len_q       <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			sidx_q      <= '0;
			dwell_q     <= '0;
			frame_q     <= '0;
			offset_q    <= '0;
			run_q       <= 1'b0;
			done_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_fire) begin
				wp_q     <= wp_d;
				len_q    <= len_d;
				col_q    <= col_d;
				idx_q    <= idx_d;
				sidx_q   <= sidx_d;
				dwell_q  <= dwell_d;
				frame_q  <= frame_d;
				offset_q <= offset_d;
				run_q    <= run_d;
				done_q   <= done_d;
			end
			// result register fills on every taken word, empties when drained
			if (item_fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// message store, read at the index the word leaves behind
	lmss_store #(
		.DEPTH(MESSAGE_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wp_q[AW-1:0]),
		.wr_data (item.data_byte),
		.rd_en   (item_fire),
		.rd_addr (idx_d),
		.rd_byte (rd_byte)
	);

	// columns past the eighth have no enable pin
	always_comb begin
		col_en_n = '1;
		for (int j = 0; j < ENABLE_W; j++) begin
			if (run_q && (j < MATRIX_SIZE) && (col_q == CW'(j))) begin
				col_en_n[j] = 1'b0;
			end
		end
	end

	assign result.column_enable_n = col_en_n;
	assign result.row_bits        = run_q ? rd_byte : 8'd0;
	assign result.running         = run_q;
	assign result.done_res        = done_q;

endmodule
